>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define EIC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition never holds at a clock edge outside reset.
`define EIC_ASSERT_NEVER(label, cond, msg) \
    `EIC_ASSERT(label, !(cond), msg)

`endif

>>> rtl/core/eic_pkg.sv
// Package for the encoder index calibration sequencer: types, constants, codes.
package eic_pkg;

    // Encoder count bits that are significant in the sampled count
    localparam int COUNT_BITS = 32;

    // Field widths
    localparam int SPEED_W  = 16;
    localparam int SETTLE_W = 8;
    localparam int VALUE_W  = 32;
    localparam int HALF_W   = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Q24.8 degree scale: x * 256 / 360 == (x << 5) / 45, done as a reciprocal
    // multiply: floor(x * ceil(2^41 / 45) / 2^36) is exact for |x| <= 2^32
    localparam int DEG_PER_TURN    = 360;
    localparam int TPD_SCALE       = 256;
    localparam int TPD_SHIFT       = 5;
    localparam int TPD_DIVISOR     = DEG_PER_TURN * (1 << TPD_SHIFT) / TPD_SCALE;
    localparam int TPD_RECIP_SHIFT = 36;
    localparam int RECIP_W         = 36;
    localparam int RECIP_HALF_W    = 18;
    localparam logic [RECIP_W-1:0] TPD_RECIP =
        RECIP_W'(((64'd1 << (TPD_RECIP_SHIFT + TPD_SHIFT)) + 64'(TPD_DIVISOR - 1))
                 / 64'(TPD_DIVISOR));
    localparam logic [RECIP_HALF_W-1:0] TPD_RECIP_HI = TPD_RECIP[RECIP_W-1:RECIP_HALF_W];
    localparam logic [RECIP_HALF_W-1:0] TPD_RECIP_LO = TPD_RECIP[RECIP_HALF_W-1:0];

    // Scale unit widths: 33-bit magnitude, 33x18 partial products, full sum
    localparam int MAG_W  = VALUE_W + 1;
    localparam int PROD_W = MAG_W + RECIP_HALF_W;
    localparam int SUM_W  = PROD_W + RECIP_HALF_W;

    // Scale unit steps: products, quotient, saturated result
    localparam int DIV_ROUNDS = 3;
    localparam int DIV_CNT_W  = $clog2(DIV_ROUNDS);

    // Register reset values
    localparam logic signed [SPEED_W-1:0] FAST_SPEED_RST   = 16'sd16384;
    localparam logic signed [SPEED_W-1:0] NORMAL_SPEED_RST = 16'sd8192;
    localparam logic [SETTLE_W-1:0]       SETTLE_RST       = 8'd25;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 16'sh8000;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [HALF_W-1:0]  half_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_SPEED   = 2'd0,
        CFG_NORMAL_SPEED = 2'd1,
        CFG_SETTLE       = 2'd2
    } cfg_idx_t;

    // Sequence phases, one-hot
    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_LEAVE  = 7'b0000010,
        PH_SETTLE = 7'b0000100,
        PH_SEEK   = 7'b0001000,
        PH_MAGNET = 7'b0010000,
        PH_SPAN   = 7'b0100000,
        PH_CENTER = 7'b1000000
    } phase_t;

endpackage

>>> rtl/core/eic_ifs.sv
// Sample and result channel interfaces for the calibration sequencer.
interface eic_in_if;
    import eic_pkg::*;

    logic   valid;
    logic   ready;
    logic   start_request;
    logic   magnet_level;
    value_t encoder_count;

    modport source (output valid, start_request, magnet_level, encoder_count, input ready);
    modport sink   (input valid, start_request, magnet_level, encoder_count, output ready);
endinterface

interface eic_out_if;
    import eic_pkg::*;

    logic   valid;
    logic   ready;
    speed_t motor_speed;
    logic   zero_encoder;
    logic   busy_res;
    logic   done_pulse;
    value_t magnet_width;
    half_t  half_width;
    value_t disk_span;
    value_t deg_scale;

    modport source (output valid, motor_speed, zero_encoder, busy_res, done_pulse,
                    magnet_width, half_width, disk_span, deg_scale,
                    input ready);
    modport sink   (input valid, motor_speed, zero_encoder, busy_res, done_pulse,
                    magnet_width, half_width, disk_span, deg_scale,
                    output ready);
endinterface

>>> rtl/core/encoder_index_calibration_sequencer.sv
// Encoder index calibration sequencer: frame-rate phase machine with result register.
//
// Usage: each transaction on in_ch carries one frame sample (start request,
// magnet sensor level, encoder count); each one gives exactly one transaction
// on out_ch with the motor command, zero request, busy/done flags and the four
// stored calibration values. cfg_we/cfg_index/cfg_data write the fast speed,
// normal speed and settle frame count; write them only while the block is idle.
// A result is presented the cycle after its sample is taken, and one
// sample per cycle is accepted while out_ch keeps up (the output register frees
// as it is taken). The frame that ends the span measurement also starts the
// degree scale divide by 45, a reciprocal multiply that forms the products,
// then the quotient, then the saturated result; that result is presented later
// than usual and in_ch is held off meanwhile. When out_ch stalls, the result
// waits in the output register and in_ch.ready drops until it is taken. Reset
// puts the sequencer idle, clears the stored values and loads the register defaults.
module encoder_index_calibration_sequencer
(
    input  logic                            clk,
    input  logic                            rst_n,
    eic_in_if.sink                          in_ch,
    eic_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [eic_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eic_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import eic_pkg::*;

    `include "assert_macros.svh"

    // Configuration registers
    speed_t              fast_speed_reg;
    speed_t              normal_speed_reg;
    logic [SETTLE_W-1:0] settle_frames_reg;

    // Sequencer state
    phase_t              phase_reg, phase_next;
    logic [SETTLE_W-1:0] settle_cnt_reg, settle_cnt_next;
    value_t              magnet_width_reg, magnet_width_next;
    half_t               half_width_reg, half_width_next;
    value_t              disk_span_reg, disk_span_next;
    value_t              tpd_reg;

    // Output register
    logic   out_valid_reg;
    speed_t motor_reg, motor_next;
    logic   zero_reg, zero_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // Degree scale unit
    logic                  div_busy_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [MAG_W-1:0]      div_mag_reg;
    logic                  div_neg_reg;
    logic [PROD_W-1:0]     prod_hi_reg, prod_hi_next;
    logic [PROD_W-1:0]     prod_lo_reg, prod_lo_next;
    logic [SUM_W-1:0]      prod_sum;
    logic [MAG_W-1:0]      quot_reg, quot_next;
    logic                  div_last;
    value_t                tpd_next;

    logic          in_fire;
    logic          div_start;
    phase_t        eff_phase;
    value_t        enc;
    value_t        half_full;
    value_t        half_ext;
    logic [MAG_W-1:0] span_sum;
    logic [MAG_W-1:0] span_mag;
    speed_t        rev_speed;

    // Handshake
    assign in_ch.ready = !div_busy_reg && (!out_valid_reg || out_ch.ready);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign div_last    = div_busy_reg && (div_cnt_reg == DIV_CNT_W'(DIV_ROUNDS - 1));

    // Sample decode and arithmetic helpers
    assign enc       = VALUE_W'($signed(in_ch.encoder_count[COUNT_BITS-1:0]));
    assign half_full = (enc + {{(VALUE_W-1){1'b0}}, enc[VALUE_W-1]}) >>> 1;
    assign half_ext  = {half_width_reg[HALF_W-1], half_width_reg};
    assign span_sum  = {enc[VALUE_W-1], enc}
                     + {magnet_width_reg[VALUE_W-1], magnet_width_reg};
    assign span_mag  = span_sum[MAG_W-1] ? (~span_sum + 33'd1) : span_sum;
    assign rev_speed = (fast_speed_reg == SPEED_MIN) ? SPEED_MAX : -fast_speed_reg;

    // Phase step for the accepted sample
    always_comb
    begin
        eff_phase = phase_reg;
        if (phase_reg == PH_IDLE && in_ch.start_request)
        begin
            eff_phase = PH_LEAVE;
        end
        phase_next        = eff_phase;
        settle_cnt_next   = settle_cnt_reg;
        magnet_width_next = magnet_width_reg;
        half_width_next   = half_width_reg;
        disk_span_next    = disk_span_reg;
        motor_next        = '0;
        zero_next         = 1'b0;
        busy_next         = (eff_phase != PH_IDLE);
        done_next         = 1'b0;
        div_start         = 1'b0;

        case (eff_phase)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_LEAVE:
            begin
                motor_next = rev_speed;
                if (in_ch.magnet_level)
                begin
                    settle_cnt_next = '0;
                    phase_next = (settle_frames_reg == '0) ? PH_SEEK : PH_SETTLE;
                end
            end
            PH_SETTLE:
            begin
                motor_next      = rev_speed;
                settle_cnt_next = settle_cnt_reg + 1'b1;
                if (settle_cnt_next >= settle_frames_reg)
                begin
                    phase_next = PH_SEEK;
                end
            end
            PH_SEEK:
            begin
                if (in_ch.magnet_level)
                begin
                    motor_next = fast_speed_reg;
                end
                else
                begin
                    zero_next  = 1'b1;
                    phase_next = PH_MAGNET;
                end
            end
            PH_MAGNET:
            begin
                if (!in_ch.magnet_level)
                begin
                    motor_next = normal_speed_reg;
                end
                else
                begin
                    magnet_width_next = enc;
                    half_width_next   = half_full[HALF_W-1:0];
                    zero_next         = 1'b1;
                    phase_next        = PH_SPAN;
                end
            end
            PH_SPAN:
            begin
                if (in_ch.magnet_level)
                begin
                    motor_next = normal_speed_reg;
                end
                else
                begin
                    disk_span_next = enc;
                    div_start      = 1'b1;
                    zero_next      = 1'b1;
                    if (half_width_reg > 0)
                    begin
                        motor_next = normal_speed_reg;
                        phase_next = PH_CENTER;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_CENTER:
            begin
                if (enc < half_ext)
                begin
                    motor_next = normal_speed_reg;
                end
                else
                begin
                    zero_next  = 1'b1;
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // Divide by 45: magnitude times the reciprocal, split in two 18-bit halves
    assign prod_hi_next = PROD_W'(div_mag_reg) * PROD_W'(TPD_RECIP_HI);
    assign prod_lo_next = PROD_W'(div_mag_reg) * PROD_W'(TPD_RECIP_LO);
    assign prod_sum     = {prod_hi_reg, {RECIP_HALF_W{1'b0}}} + SUM_W'(prod_lo_reg);
    assign quot_next    = prod_sum[TPD_RECIP_SHIFT +: MAG_W];

    // Truncated quotient, sign restored and saturated to 32 bits
    always_comb
    begin
        if (!div_neg_reg)
        begin
            tpd_next = (quot_reg > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : quot_reg[31:0];
        end
        else
        begin
            tpd_next = (quot_reg > 33'h0_8000_0000) ? 32'sh8000_0000 : -quot_reg[31:0];
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_speed_reg    <= FAST_SPEED_RST;
            normal_speed_reg  <= NORMAL_SPEED_RST;
            settle_frames_reg <= SETTLE_RST;
            phase_reg         <= PH_IDLE;
            settle_cnt_reg    <= '0;
            magnet_width_reg  <= '0;
            half_width_reg    <= '0;
            disk_span_reg     <= '0;
            tpd_reg           <= '0;
            out_valid_reg     <= 1'b0;
            div_busy_reg      <= 1'b0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            // Configuration writes; unknown indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FAST_SPEED:   fast_speed_reg    <= cfg_data;
                    CFG_NORMAL_SPEED: normal_speed_reg  <= cfg_data;
                    CFG_SETTLE:       settle_frames_reg <= cfg_data[SETTLE_W-1:0];
                    default:          ;
                endcase
            end

            if (in_fire)
            begin
                phase_reg        <= phase_next;
                settle_cnt_reg   <= settle_cnt_next;
                magnet_width_reg <= magnet_width_next;
                half_width_reg   <= half_width_next;
                disk_span_reg    <= disk_span_next;
                out_valid_reg    <= !div_start;
            end
            else if (div_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Scale unit sequencing
            if (in_fire && div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    div_busy_reg <= 1'b0;
                    tpd_reg      <= tpd_next;
                end
            end
        end
    end

    // Result payload and scale unit datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            motor_reg <= motor_next;
            zero_reg  <= zero_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
        if (in_fire && div_start)
        begin
            div_mag_reg <= span_mag;
            div_neg_reg <= span_sum[MAG_W-1];
        end
        if (div_busy_reg)
        begin
            prod_hi_reg <= prod_hi_next;
            prod_lo_reg <= prod_lo_next;
            quot_reg    <= quot_next;
        end
    end

    // Output channel
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.motor_speed  = motor_reg;
    assign out_ch.zero_encoder = zero_reg;
    assign out_ch.busy_res     = busy_reg;
    assign out_ch.done_pulse   = done_reg;
    assign out_ch.magnet_width = magnet_width_reg;
    assign out_ch.half_width   = half_width_reg;
    assign out_ch.disk_span    = disk_span_reg;
    assign out_ch.deg_scale    = tpd_reg;

    // Checks
    `EIC_ASSERT_NEVER(a_div_hides_result, div_busy_reg && out_valid_reg, "result shown during divide")
    `EIC_ASSERT(a_div_ends_valid, div_last |=> out_valid_reg, "divide end did not present result")
    `EIC_ASSERT(a_done_zeroes, (out_valid_reg && done_reg) |-> zero_reg, "done without zeroing")

endmodule
